// ----- rtl/core/arf_pkg.sv -----
// Shared types and constants for the Aitken relaxation factor block.
`default_nettype none
package arf_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned FACTOR_W   = FRAC_BITS + 1;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned ITER_W     = 10;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned MAX_COMP   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = FACTOR_W;

  localparam logic [FACTOR_W-1:0] ONE_Q       = FACTOR_W'(1) << FRAC_BITS;
  localparam logic [ITER_W-1:0]   EARLY_LIMIT = ITER_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_INIT_RELAX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_THR  = 1'b1;

  localparam logic [FACTOR_W-1:0] INIT_RELAX_RST = FACTOR_W'(32768);
  localparam logic [THR_W-1:0]    SMALL_THR_RST  = THR_W'(1);

  typedef struct packed {
    logic load;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic                done;
    logic                over;
    logic [FACTOR_W-1:0] quot;
  } div_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/aitken_relaxation_factor.sv -----
// Top level: Aitken dynamic relaxation factor over a stream of interface elements.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  in       | start / busy       | res_x..z, prev_x..z, iteration, last
//  out      | done (1-cycle)     | relax_factor, clipped_to_one, reset_to_initial,
//           |                    | early_iteration
//  cfg      | cfg_we             | cfg_idx, cfg_data
//
// A beat that is not last passes through the lane multiply, the merge load and one
// saturating add per lane in the merge stage. A last beat with iteration below 3 takes
// the same path; otherwise the serial divider follows (shift-add product, then one
// quotient bit per cycle). busy is high for the whole time.
// rst is synchronous: factor and accumulators clear, registers take their defaults.
// The receiver cannot stall; each result is shown for one cycle with done.
`default_nettype none
module aitken_relaxation_factor
  import arf_pkg::*;
#(
  parameter int unsigned COMPONENTS = 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [RES_W-1:0] res_x,
  input  wire logic signed [RES_W-1:0] res_y,
  input  wire logic signed [RES_W-1:0] res_z,
  input  wire logic signed [RES_W-1:0] prev_x,
  input  wire logic signed [RES_W-1:0] prev_y,
  input  wire logic signed [RES_W-1:0] prev_z,
  input  wire logic [ITER_W-1:0]       iteration,
  input  wire logic                    last,
  output logic                         done,
  output logic [FACTOR_W-1:0]          relax_factor,
  output logic                         clipped_to_one,
  output logic                         reset_to_initial,
  output logic                         early_iteration,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ACC,
    S_DIV
  } state_t;

  state_t               state;
  logic [FACTOR_W-1:0]  init_relax;
  logic [THR_W-1:0]     small_threshold;
  logic [FACTOR_W-1:0]  factor_reg;
  logic                 last_r;
  logic [ITER_W-1:0]    iter_r;
  logic                 accept;
  acc_ctrl_t            acc_ctrl;
  logic                 div_start;
  div_res_t             div_res;

  logic signed [RES_W-1:0] cur_in [MAX_COMP];
  logic signed [RES_W-1:0] prv_in [MAX_COMP];
  logic signed [ACC_W-1:0] num_prod [COMPONENTS];
  logic        [ACC_W-1:0] den_prod [COMPONENTS];
  logic signed [ACC_W-1:0] num_acc;
  logic        [ACC_W-1:0] den_acc;
  logic                    acc_done;
  logic        [ACC_W-1:0] num_mag;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign cur_in[0] = res_x;
  assign cur_in[1] = res_y;
  assign cur_in[2] = res_z;
  assign prv_in[0] = prev_x;
  assign prv_in[1] = prev_y;
  assign prv_in[2] = prev_z;

  for (genvar c = 0; c < COMPONENTS; c++) begin : g_lane
    arf_lane u_lane (
      .clk      (clk),
      .en       (accept),
      .cur      (cur_in[c]),
      .prv      (prv_in[c]),
      .num_prod (num_prod[c]),
      .den_prod (den_prod[c])
    );
  end

  arf_merge #(
    .COMPONENTS (COMPONENTS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (acc_ctrl),
    .num_prod (num_prod),
    .den_prod (den_prod),
    .num_acc  (num_acc),
    .den_acc  (den_acc),
    .done     (acc_done)
  );

  assign num_mag = num_acc[ACC_W-1] ? ACC_W'(-num_acc) : ACC_W'(num_acc);

  arf_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .factor  (factor_reg),
    .num_mag (num_mag),
    .den     (den_acc),
    .res     (div_res)
  );

  always_comb begin
    acc_ctrl.load  = (state == S_LOAD);
    acc_ctrl.clear = (state == S_ACC && acc_done && last_r && iter_r < EARLY_LIMIT)
                     || (state == S_DIV && div_res.done);
    div_start      = (state == S_ACC && acc_done && last_r && iter_r >= EARLY_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_relax      <= INIT_RELAX_RST;
      small_threshold <= SMALL_THR_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_INIT_RELAX: init_relax <= (cfg_data > ONE_Q) ? ONE_Q : cfg_data;
        REG_SMALL_THR:  small_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      factor_reg <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_r <= last;
            iter_r <= iteration;
            state  <= S_LOAD;
          end
        end
        S_LOAD: state <= S_ACC;
        S_ACC: begin
          if (acc_done) begin
            if (!last_r) begin
              state <= S_IDLE;
            end else if (iter_r < EARLY_LIMIT) begin
              factor_reg       <= (factor_reg < init_relax) ? init_relax : factor_reg;
              relax_factor     <= (factor_reg < init_relax) ? init_relax : factor_reg;
              clipped_to_one   <= 1'b0;
              reset_to_initial <= 1'b0;
              early_iteration  <= 1'b1;
              done             <= 1'b1;
              state            <= S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            early_iteration <= 1'b0;
            done            <= 1'b1;
            state           <= S_IDLE;
            if (div_res.over) begin
              factor_reg       <= ONE_Q;
              relax_factor     <= ONE_Q;
              clipped_to_one   <= 1'b1;
              reset_to_initial <= 1'b0;
            end else if (div_res.quot < FACTOR_W'(small_threshold)) begin
              factor_reg       <= init_relax;
              relax_factor     <= init_relax;
              clipped_to_one   <= 1'b0;
              reset_to_initial <= 1'b1;
            end else begin
              factor_reg       <= div_res.quot;
              relax_factor     <= div_res.quot;
              clipped_to_one   <= 1'b0;
              reset_to_initial <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> relax_factor <= ONE_Q)
    else $error("factor above one");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> $countones({clipped_to_one, reset_to_initial, early_iteration}) <= 1)
    else $error("more than one status flag set");

endmodule
`default_nettype wire

// ----- rtl/core/arf_lane.sv -----
// One lane: difference and the two products for a single residual component.
`default_nettype none
module arf_lane
  import arf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [RES_W-1:0] cur,
  input  wire logic signed [RES_W-1:0] prv,
  output logic signed [ACC_W-1:0]      num_prod,
  output logic        [ACC_W-1:0]      den_prod
);

  logic signed [RES_W:0]   diff;
  logic        [RES_W-1:0] diff_mag;
  logic signed [ACC_W:0]   num_full;

  assign diff     = (RES_W+1)'(cur) - (RES_W+1)'(prv);
  assign diff_mag = diff[RES_W] ? RES_W'(-diff) : RES_W'(diff);
  assign num_full = (ACC_W+1)'(prv) * (ACC_W+1)'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      num_prod <= ACC_W'(num_full);
      den_prod <= ACC_W'(diff_mag) * ACC_W'(diff_mag);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/arf_merge.sv -----
// Merge stage: saturating accumulation of lane products, one lane per cycle.
`default_nettype none
module arf_merge
  import arf_pkg::*;
#(
  parameter int unsigned COMPONENTS = 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire acc_ctrl_t               ctrl,
  input  wire logic signed [ACC_W-1:0] num_prod [COMPONENTS],
  input  wire logic        [ACC_W-1:0] den_prod [COMPONENTS],
  output logic signed [ACC_W-1:0]      num_acc,
  output logic        [ACC_W-1:0]      den_acc,
  output logic                         done
);

  localparam int unsigned CNT_W = $clog2(COMPONENTS + 1);

  localparam logic signed [ACC_W:0] S_MAX = (ACC_W+1)'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [ACC_W:0] S_MIN = -S_MAX - (ACC_W+1)'(1);

  logic signed [ACC_W-1:0] num_q [COMPONENTS];
  logic        [ACC_W-1:0] den_q [COMPONENTS];
  logic        [CNT_W-1:0] cnt;
  logic signed [ACC_W:0]   num_sum;
  logic        [ACC_W:0]   den_sum;
  logic signed [ACC_W-1:0] num_next;
  logic        [ACC_W-1:0] den_next;

  always_comb begin
    num_sum = {num_acc[ACC_W-1], num_acc} + {num_q[0][ACC_W-1], num_q[0]};
    den_sum = {1'b0, den_acc} + {1'b0, den_q[0]};
    if (num_sum > S_MAX) begin
      num_next = ACC_W'(S_MAX);
    end else if (num_sum < S_MIN) begin
      num_next = ACC_W'(S_MIN);
    end else begin
      num_next = ACC_W'(num_sum);
    end
    den_next = den_sum[ACC_W] ? '1 : den_sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      done    <= 1'b0;
      num_acc <= '0;
      den_acc <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.clear) begin
        num_acc <= '0;
        den_acc <= '0;
      end else if (ctrl.load) begin
        cnt <= CNT_W'(COMPONENTS);
      end else if (cnt != '0) begin
        num_acc <= num_next;
        den_acc <= den_next;
        cnt     <= cnt - CNT_W'(1);
        done    <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < COMPONENTS; i++) begin
        num_q[i] <= num_prod[i];
        den_q[i] <= den_prod[i];
      end
    end else begin
      for (int i = 0; i < COMPONENTS - 1; i++) begin
        num_q[i] <= num_q[i+1];
        den_q[i] <= den_q[i+1];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/arf_div.sv -----
// Serial unit: floor(factor * |num| / divisor), shift-add product then restoring division.
`default_nettype none
module arf_div
  import arf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [FACTOR_W-1:0] factor,
  input  wire logic [ACC_W-1:0]    num_mag,
  input  wire logic [ACC_W-1:0]    den,
  output div_res_t                 res
);

  localparam int unsigned PROD_W = FACTOR_W + ACC_W;
  localparam int unsigned CNT_W  = $clog2(PROD_W + 1);
  localparam int unsigned Q_W    = FACTOR_W + 1;

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_DIV
  } div_state_t;

  div_state_t           state;
  logic [CNT_W-1:0]     cnt;
  logic [FACTOR_W-1:0]  f_sh;
  logic [ACC_W-1:0]     n_r;
  logic [ACC_W-1:0]     dv_r;
  logic [PROD_W-1:0]    prod;
  logic [ACC_W-1:0]     rem;
  logic [Q_W-1:0]       quot;
  logic                 ovf;

  logic [ACC_W:0]       rem_sh;
  logic                 q_bit;
  logic [ACC_W-1:0]     rem_next;
  logic [Q_W-1:0]       quot_next;
  logic                 ovf_next;

  always_comb begin
    rem_sh    = {rem, prod[PROD_W-1]};
    q_bit     = (rem_sh >= {1'b0, dv_r});
    rem_next  = q_bit ? ACC_W'(rem_sh - {1'b0, dv_r}) : rem_sh[ACC_W-1:0];
    quot_next = {quot[Q_W-2:0], q_bit};
    ovf_next  = ovf | quot[Q_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      cnt      <= '0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            f_sh  <= factor;
            n_r   <= num_mag;
            dv_r  <= (den == '1) ? den : den + ACC_W'(1);
            prod  <= '0;
            rem   <= '0;
            quot  <= '0;
            ovf   <= 1'b0;
            cnt   <= CNT_W'(FACTOR_W);
            state <= D_MUL;
          end
        end
        D_MUL: begin
          prod <= {prod[PROD_W-2:0], 1'b0} + (f_sh[FACTOR_W-1] ? PROD_W'(n_r) : '0);
          f_sh <= {f_sh[FACTOR_W-2:0], 1'b0};
          if (cnt == CNT_W'(1)) begin
            cnt   <= CNT_W'(PROD_W);
            state <= D_DIV;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        D_DIV: begin
          rem  <= rem_next;
          prod <= {prod[PROD_W-2:0], 1'b0};
          quot <= quot_next;
          ovf  <= ovf_next;
          cnt  <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            res.done <= 1'b1;
            res.over <= ovf_next || (quot_next > Q_W'(ONE_Q));
            res.quot <= quot_next[FACTOR_W-1:0];
            state    <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
